// ----- rtl/lfurp_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU replacement policy package
// Shared sizes, the per-cell write command and the victim candidate record.
// ----------------------------------------------------------------------------
package lfurp_pkg;

  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_W     = 64;
  localparam int TIME_W     = 64;
  localparam int CFG_W      = 5;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LIM_W      = $clog2(CAPACITY + 1);
  localparam int OUT_DATA_W = ((ADDR_W + SLOT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic              wr;
    logic              inc;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } cell_cmd_t;

  typedef struct packed {
    logic                  have;
    logic [COUNT_BITS-1:0] count;
    logic [TIME_W-1:0]     stamp;
    logic [IDX_W-1:0]      idx;
    logic [ADDR_W-1:0]     addr;
  } cand_t;

endpackage

// ----- rtl/lfurp_cell.sv -----
// ----------------------------------------------------------------------------
// LFU replacement cell
// Holds one tag entry, matches it against the request address and passes the
// best victim candidate so far on to the next cell each cycle.
// ----------------------------------------------------------------------------
module lfurp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lfurp_pkg::IDX_W-1:0]  cell_idx,
  input  lfurp_pkg::cell_cmd_t      cmd,
  input  logic                      kill,
  input  logic [lfurp_pkg::ADDR_W-1:0] key,
  input  lfurp_pkg::cand_t          cand_in,
  output logic                      valid,
  output logic                      match,
  output lfurp_pkg::cand_t          cand_out
);

  logic                                valid_r;
  logic [lfurp_pkg::ADDR_W-1:0]        addr_r;
  logic [lfurp_pkg::COUNT_BITS-1:0]    count_r;
  logic [lfurp_pkg::TIME_W-1:0]        stamp_r;
  lfurp_pkg::cand_t                    cand_r;
  logic                                sel;
  logic                                better;

  assign sel = cmd.wr && (cmd.slot == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end else if (kill) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      addr_r  <= cmd.addr;
      stamp_r <= cmd.stamp;
      if (!cmd.inc) begin
        count_r <= lfurp_pkg::COUNT_BITS'(1);
      end else if (count_r != {lfurp_pkg::COUNT_BITS{1'b1}}) begin
        count_r <= count_r + lfurp_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    better = valid_r && (!cand_in.have || (count_r < cand_in.count) ||
             ((count_r == cand_in.count) && (stamp_r < cand_in.stamp)));
  end

  always_ff @(posedge clk) begin
    if (better) begin
      cand_r.have  <= 1'b1;
      cand_r.count <= count_r;
      cand_r.stamp <= stamp_r;
      cand_r.idx   <= cell_idx;
      cand_r.addr  <= addr_r;
    end else begin
      cand_r <= cand_in;
    end
  end

  assign valid    = valid_r;
  assign match    = valid_r && (addr_r == key);
  assign cand_out = cand_r;

endmodule

// ----- rtl/lfu_replacement_policy_core.sv -----
// ----------------------------------------------------------------------------
// LFU replacement policy core
// Fully associative tag store with least-frequently-used replacement and
// least-recently-used tie-break, built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the in_ channel carries one access address. The result on
// the out_ channel reports hit or miss, whether a resident entry was evicted,
// the evicted address and the slot that was hit or filled.
// The cfg_ channel writes the number of entries in use; it is accepted at any
// time but should only be written while no request is in flight. Shrinking
// the limit drops every entry at or beyond the new limit.
// A hit or a fill into a free slot goes from the lookup state straight to the
// finish state; a miss with all slots in use passes through the search state
// first, because the victim candidate walks along the row of cells one cell
// per cycle. The next request is accepted in the same cycle as the result
// appears. When the receiver stalls, the result is held in the output
// register and a finished request waits until that register is free.
// Reset empties the store, clears the access clock and sets the limit to 16.
// ----------------------------------------------------------------------------
module lfu_replacement_policy_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: access_address[63:0]
  input  logic [lfurp_pkg::ADDR_W-1:0]      in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: victim_address[63:0], slot[67:64], zero padding[71:68]
  output logic [lfurp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: hit[0], evicted[1]
  output logic [lfurp_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [lfurp_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int CAP = lfurp_pkg::CAPACITY;
  localparam int IW  = lfurp_pkg::IDX_W;
  localparam int LW  = lfurp_pkg::LIM_W;

  logic [1:0]                        state_r, state_nxt;
  logic [lfurp_pkg::CFG_W-1:0]       limit_reg_r;
  logic [lfurp_pkg::ADDR_W-1:0]      addr_r;
  logic [lfurp_pkg::TIME_W-1:0]      clock_r;
  logic [LW-1:0]                     srch_cnt_r, srch_cnt_nxt;
  logic                              res_hit_r, res_hit_nxt;
  logic                              res_evict_r, res_evict_nxt;
  logic [lfurp_pkg::ADDR_W-1:0]      res_victim_r, res_victim_nxt;
  logic [IW-1:0]                     res_slot_r, res_slot_nxt;
  logic                              out_valid_r;
  logic [lfurp_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [lfurp_pkg::OUT_USER_W-1:0]  out_user_r;

  logic [LW-1:0]                     lim;
  logic [LW-1:0]                     new_lim;
  logic                              in_acc;
  logic                              cfg_acc;
  logic                              fire;
  logic [CAP-1:0]                    valid_v;
  logic [CAP-1:0]                    match_v;
  logic [CAP-1:0]                    kill_v;
  lfurp_pkg::cand_t                  chain [CAP+1];
  lfurp_pkg::cell_cmd_t              cmd;
  logic                              any_hit;
  logic [IW-1:0]                     hit_idx;
  logic                              any_free;
  logic [IW-1:0]                     free_idx;
  logic [IW+lfurp_pkg::SLOT_W-1:0]   slot_ext;

  function automatic logic [LW-1:0] clamp_limit(input logic [lfurp_pkg::CFG_W-1:0] v);
    logic [LW-1:0] r;
    if (v == '0) begin
      r = LW'(1);
    end else if (32'(v) > CAP) begin
      r = LW'(CAP);
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  assign lim       = clamp_limit(limit_reg_r);
  assign new_lim   = clamp_limit(cfg_data);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fire      = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    cmd.wr    = fire;
    cmd.inc   = res_hit_r;
    cmd.slot  = res_slot_r;
    cmd.addr  = addr_r;
    cmd.stamp = clock_r;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    assign kill_v[i] = cfg_acc && (32'(i) >= 32'(new_lim));
    lfurp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IW'(i)),
      .cmd      (cmd),
      .kill     (kill_v[i]),
      .key      (addr_r),
      .cand_in  (chain[i]),
      .valid    (valid_v[i]),
      .match    (match_v[i]),
      .cand_out (chain[i+1])
    );
  end

  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        any_hit = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_v[i] && (i < 32'(lim))) begin
        any_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    srch_cnt_nxt   = srch_cnt_r;
    res_hit_nxt    = res_hit_r;
    res_evict_nxt  = res_evict_r;
    res_victim_nxt = res_victim_r;
    res_slot_nxt   = res_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_victim_nxt = '0;
        res_evict_nxt  = 1'b0;
        srch_cnt_nxt   = '0;
        if (any_hit) begin
          res_hit_nxt  = 1'b1;
          res_slot_nxt = hit_idx;
          state_nxt    = ST_FINISH;
        end else if (any_free) begin
          res_hit_nxt  = 1'b0;
          res_slot_nxt = free_idx;
          state_nxt    = ST_FINISH;
        end else begin
          res_hit_nxt  = 1'b0;
          state_nxt    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        srch_cnt_nxt = srch_cnt_r + LW'(1);
        if (srch_cnt_r == LW'(CAP - 1)) begin
          res_evict_nxt  = 1'b1;
          res_victim_nxt = chain[CAP].addr;
          res_slot_nxt   = chain[CAP].idx;
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_reg_r <= lfurp_pkg::CFG_W'(16);
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        limit_reg_r <= cfg_data;
      end
      if (in_acc) begin
        clock_r <= clock_r + lfurp_pkg::TIME_W'(1);
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = {{lfurp_pkg::SLOT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    srch_cnt_r   <= srch_cnt_nxt;
    res_hit_r    <= res_hit_nxt;
    res_evict_r  <= res_evict_nxt;
    res_victim_r <= res_victim_nxt;
    res_slot_r   <= res_slot_nxt;
    if (in_acc) begin
      addr_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= lfurp_pkg::OUT_DATA_W'({slot_ext[lfurp_pkg::SLOT_W-1:0], res_victim_r});
      out_user_r <= {res_evict_r, res_hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/lfurp_checker.sv -----
// ----------------------------------------------------------------------------
// LFU replacement policy checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module lfurp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [lfurp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [lfurp_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("hit reported together with eviction");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[lfurp_pkg::ADDR_W-1:0] == '0)
    else $error("victim address not zero without eviction");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

endmodule

bind lfu_replacement_policy_core lfurp_checker u_lfurp_checker (.*);

// ----- test/tb_lfu_replacement_policy_core.sv -----
// ----------------------------------------------------------------------------
// LFU replacement policy core testbench
// Sends access requests and compares every result with a local tag store
// that applies least-frequently-used replacement with an oldest-use
// tie-break. Directed sequences cover the address extremes, eviction order
// and the entry limit; random sequences reuse a skewed working set under
// varied stalls on both channels.
// ----------------------------------------------------------------------------
module tb_lfu_replacement_policy_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = lfurp_pkg::CAPACITY + 8;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic                         hit;
    logic                         evicted;
    logic [lfurp_pkg::ADDR_W-1:0] victim;
    logic [lfurp_pkg::SLOT_W-1:0] slot;
  } lookup_result_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic [lfurp_pkg::ADDR_W-1:0]     in_tdata   = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [lfurp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lfurp_pkg::OUT_USER_W-1:0] out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [lfurp_pkg::CFG_W-1:0]      cfg_data   = '0;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;

  logic [lfurp_pkg::ADDR_W-1:0]     tag_addr  [lfurp_pkg::CAPACITY];
  logic [lfurp_pkg::COUNT_BITS-1:0] tag_count [lfurp_pkg::CAPACITY];
  logic [lfurp_pkg::TIME_W-1:0]     tag_stamp [lfurp_pkg::CAPACITY];
  logic                             tag_valid [lfurp_pkg::CAPACITY];
  logic [lfurp_pkg::TIME_W-1:0]     model_clock;
  logic [lfurp_pkg::CFG_W-1:0]      limit_reg;

  lookup_result_t                   pending_results[$];
  logic [lfurp_pkg::ADDR_W-1:0]     addr_pool[POOL_SIZE];
  int unsigned                      src_idle_pct  = 11;
  int unsigned                      sink_idle_pct = 57;
  int unsigned                      mismatches    = 0;

  lfu_replacement_policy_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic int unsigned effective_limit();
    int unsigned v;
    v = 32'(limit_reg);
    if (v == 0) v = 1;
    if (v > lfurp_pkg::CAPACITY) v = lfurp_pkg::CAPACITY;
    return v;
  endfunction

  function automatic lookup_result_t predict_lookup(
    input logic [lfurp_pkg::ADDR_W-1:0] addr
  );
    lookup_result_t                   r;
    int unsigned                      lim;
    int                               sel;
    logic                             found;
    logic                             have;
    logic [lfurp_pkg::COUNT_BITS-1:0] best_count;
    logic [lfurp_pkg::TIME_W-1:0]     best_stamp;
    r = '0;
    lim = effective_limit();
    sel = 0;
    found = 1'b0;
    have = 1'b0;
    best_count = '0;
    best_stamp = '0;
    model_clock = model_clock + lfurp_pkg::TIME_W'(1);
    for (int i = 0; i < lim; i++) begin
      if (!found && tag_valid[i] && tag_addr[i] == addr) begin
        sel = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (tag_count[sel] != '1) begin
        tag_count[sel] = tag_count[sel] + lfurp_pkg::COUNT_BITS'(1);
      end
      tag_stamp[sel] = model_clock;
      r.hit = 1'b1;
      r.slot = lfurp_pkg::SLOT_W'(sel);
      return r;
    end
    for (int i = 0; i < lim; i++) begin
      if (!found && !tag_valid[i]) begin
        sel = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < lim; i++) begin
        if (tag_valid[i] && (!have || tag_count[i] < best_count ||
            (tag_count[i] == best_count && tag_stamp[i] < best_stamp))) begin
          have = 1'b1;
          best_count = tag_count[i];
          best_stamp = tag_stamp[i];
          sel = i;
        end
      end
      r.evicted = 1'b1;
      r.victim = tag_addr[sel];
    end
    tag_addr[sel] = addr;
    tag_count[sel] = lfurp_pkg::COUNT_BITS'(1);
    tag_stamp[sel] = model_clock;
    tag_valid[sel] = 1'b1;
    r.slot = lfurp_pkg::SLOT_W'(sel);
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tuser %0h tdata %0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser[0] !== exp_r.hit) begin
          $error("hit: expected %0h, got %0h", exp_r.hit, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== exp_r.evicted) begin
          $error("evicted: expected %0h, got %0h", exp_r.evicted, out_tuser[1]);
          mismatches++;
        end
        if (out_tdata[lfurp_pkg::ADDR_W-1:0] !== exp_r.victim) begin
          $error("victim_address: expected %0h, got %0h", exp_r.victim,
                 out_tdata[lfurp_pkg::ADDR_W-1:0]);
          mismatches++;
        end
        if (out_tdata[lfurp_pkg::ADDR_W +: lfurp_pkg::SLOT_W] !== exp_r.slot) begin
          $error("slot: expected %0h, got %0h", exp_r.slot,
                 out_tdata[lfurp_pkg::ADDR_W +: lfurp_pkg::SLOT_W]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_access(input logic [lfurp_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= addr;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_lookup(addr));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lfurp_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
    for (int i = effective_limit(); i < lfurp_pkg::CAPACITY; i++) tag_valid[i] = 1'b0;
  endtask

  function automatic logic [lfurp_pkg::ADDR_W-1:0] random_address();
    return {$urandom, $urandom};
  endfunction

  task automatic test_fill_and_hit();
    send_access('0);
    send_access('1);
    send_access('0);
    send_access('1);
    send_access(64'h5555_5555_5555_5555);
    send_access(64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_lfu_tiebreak();
    write_limit(5'd3);
    send_access(64'h0000_0000_0000_1000);
    send_access(64'h0000_0000_0000_2000);
    send_access(64'h0000_0000_0000_3000);
    send_access(64'h0000_0000_0000_1000);
    send_access(64'h0000_0000_0000_2000);
    send_access(64'h0000_0000_0000_4000);
    send_access(64'h0000_0000_0000_3000);
    send_access(64'h0000_0000_0000_4000);
  endtask

  task automatic test_limit_extremes();
    write_limit(5'd0);
    send_access(64'h8000_0000_0000_0001);
    send_access(64'h8000_0000_0000_0001);
    send_access(64'h7FFF_FFFF_FFFF_FFFE);
    write_limit(5'd31);
    send_access(64'h0123_4567_89AB_CDEF);
    send_access(64'hFEDC_BA98_7654_3210);
  endtask

  task automatic test_limit_shrink();
    write_limit(5'd16);
    for (int i = 0; i < 5; i++) send_access(64'hC0DE_0000_0000_0000 + 64'(i));
    write_limit(5'd2);
    send_access(64'hC0DE_0000_0000_0004);
  endtask

  task automatic test_random_accesses(input logic [lfurp_pkg::CFG_W-1:0] lim0,
                                      input logic [lfurp_pkg::CFG_W-1:0] lim1,
                                      input logic [lfurp_pkg::CFG_W-1:0] lim2);
    logic [lfurp_pkg::CFG_W-1:0]  plan[3];
    logic [lfurp_pkg::ADDR_W-1:0] addr;
    int unsigned                  span;
    plan = '{lim0, lim1, lim2};
    for (int seg = 0; seg < 3; seg++) begin
      write_limit(plan[seg]);
      span = effective_limit() + 4;
      if (span > POOL_SIZE) span = POOL_SIZE;
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(99) < 75) begin
          addr = addr_pool[$urandom_range(0, $urandom_range(0, span - 1))];
        end else begin
          addr = random_address();
          if ($urandom_range(1)) addr_pool[$urandom_range(0, POOL_SIZE - 1)] = addr;
        end
        send_access(addr);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < lfurp_pkg::CAPACITY; i++) begin
      tag_addr[i]  = '0;
      tag_count[i] = '0;
      tag_stamp[i] = '0;
      tag_valid[i] = 1'b0;
    end
    model_clock = '0;
    limit_reg = 5'd16;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_address();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_hit();
    test_lfu_tiebreak();
    test_limit_extremes();
    test_limit_shrink();

    test_random_accesses(5'd1, 5'd31, 5'($urandom_range(2, 15)));
    src_idle_pct = 57;
    sink_idle_pct = 11;
    test_random_accesses(5'd16, 5'd0, 5'($urandom_range(2, 15)));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_accesses(5'($urandom_range(0, 31)), 5'd3, 5'd16);

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lfurp_pkg.sv
rtl/lfurp_cell.sv
rtl/lfu_replacement_policy_core.sv
rtl/lfurp_checker.sv
test/tb_lfu_replacement_policy_core.sv
